/* rtl/teleop_setpoint_integrator_unit_defines.svh */
// Assertion macros for the teleop setpoint integrator.
`ifndef TELEOP_SETPOINT_INTEGRATOR_UNIT_DEFINES_SVH
`define TELEOP_SETPOINT_INTEGRATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define TSI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TSI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TSI_ASSERT(label, prop, msg)
`define TSI_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* rtl/tsi_pkg.sv */
// Package with constants, types and tables of the teleop setpoint integrator.
`timescale 1ns / 1ps
package tsi_pkg;

    localparam int IN_BITS  = 176;
    localparam int OUT_BITS = 120;

    localparam logic signed [33:0] Q_PI        = 34'sd205887;
    localparam logic signed [33:0] Q_HALF_PI   = 34'sd102944;
    localparam logic signed [33:0] Q_TWO_PI    = 34'sd411774;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [15:0] STEP_TIME_RST = 16'd3277;
    localparam logic [17:0] YAW_RATE_RST  = 18'd131072;
    localparam logic [30:0] POS_LIMIT_RST = 31'd65536;
    localparam logic [17:0] YAW_LIMIT_RST = 18'd205887;
    localparam logic signed [31:0] GOAL_Z_RST = 32'sd65536;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_STEP_TIME = 2'd0;
    localparam logic [1:0] REG_YAW_RATE  = 2'd1;
    localparam logic [1:0] REG_POS_LIMIT = 2'd2;
    localparam logic [1:0] REG_YAW_LIMIT = 2'd3;

    // Command codes carried in tuser.
    localparam logic CMD_JOYSTICK = 1'b0;
    localparam logic CMD_POSE     = 1'b1;

    // Pad codes.
    localparam logic [1:0] PAD_PLUS  = 2'b01;
    localparam logic [1:0] PAD_MINUS = 2'b11;

    // Steps of the multiply sequence.
    localparam logic [3:0] MS_TRIG   = 4'd0;
    localparam logic [3:0] MS_PC     = 4'd1;
    localparam logic [3:0] MS_RS     = 4'd2;
    localparam logic [3:0] MS_XDIFF  = 4'd3;
    localparam logic [3:0] MS_XDT    = 4'd4;
    localparam logic [3:0] MS_GX     = 4'd5;
    localparam logic [3:0] MS_RC     = 4'd6;
    localparam logic [3:0] MS_YSUM   = 4'd7;
    localparam logic [3:0] MS_YDT    = 4'd8;
    localparam logic [3:0] MS_GY     = 4'd9;
    localparam logic [3:0] MS_GZ     = 4'd10;
    localparam logic [3:0] MS_GH     = 4'd11;
    localparam logic [3:0] MS_BUTTON = 4'd12;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ROT   = 6'b000010,
        ST_MAC   = 6'b000100,
        ST_CLAMP = 6'b001000,
        ST_WRAP  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    // Arctangent of 2^-i in Q4.16 radians.
    function automatic logic signed [20:0] atan_lut(input logic [3:0] i);
        logic signed [20:0] r;
        unique case (i)
            4'd0:    r = 21'sd51472;
            4'd1:    r = 21'sd30385;
            4'd2:    r = 21'sd16055;
            4'd3:    r = 21'sd8150;
            4'd4:    r = 21'sd4091;
            4'd5:    r = 21'sd2047;
            4'd6:    r = 21'sd1024;
            4'd7:    r = 21'sd512;
            4'd8:    r = 21'sd256;
            4'd9:    r = 21'sd128;
            4'd10:   r = 21'sd64;
            4'd11:   r = 21'sd32;
            4'd12:   r = 21'sd16;
            4'd13:   r = 21'sd8;
            4'd14:   r = 21'sd4;
            default: r = 21'sd2;
        endcase
        return r;
    endfunction

endpackage

/* rtl/teleop_setpoint_integrator_unit.sv */
// Top level of the teleop setpoint integrator: sequencer, CORDIC, shared multiplier.
//
// Channel  Direction  Accepted when            Carries
// s_*      in         s_tvalid && s_tready     one command word (joystick or pose)
// m_*      out        m_tvalid && m_tready     one setpoint word per pose command
// cfg_*    in         cfg_we                   one register write
//
// A joystick word runs 16 CORDIC rotations on one shift-add unit, then 13 steps
// around one 49 x 18 bit multiplier. A pose word goes through clamping and
// wrapping on one compare unit, plus any wait for the output register to free
// up. s_tready is high only while the sequencer is idle.
// rst_n clears all state at once; there is no clearing pass.
`timescale 1ns / 1ps
`include "teleop_setpoint_integrator_unit_defines.svh"
module teleop_setpoint_integrator_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // throttle, pitch, roll, yaw_buttons, reset_button, pad_vertical,
    // pad_horizontal, pos_x, pos_y, pos_z, pos_yaw, zero fill
    input  logic [tsi_pkg::IN_BITS-1:0]  s_tdata,
    // command
    input  logic                         s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // set_x, set_y, set_z, set_yaw, zero fill
    output logic [tsi_pkg::OUT_BITS-1:0] m_tdata,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_addr,
    input  logic [30:0]                  cfg_data
);
    import tsi_pkg::*;

    state_t state_reg, state_next;

    logic [15:0] step_time_reg;
    logic [17:0] yaw_rate_reg, yaw_limit_reg;
    logic [30:0] pos_limit_reg;

    logic signed [31:0] goal_x_reg, goal_y_reg, goal_z_reg, goal_h_reg;
    logic signed [31:0] goal_x_next, goal_y_next, goal_z_next, goal_h_next;
    logic signed [31:0] seen_x_reg, seen_y_reg, seen_z_reg;
    logic signed [31:0] seen_x_next, seen_y_next, seen_z_next;
    logic signed [18:0] seen_h_reg, seen_h_next;

    logic signed [15:0] thr_reg, pit_reg, rol_reg, thr_next, pit_next, rol_next;
    logic [1:0] btn_reg, pv_reg, ph_reg, btn_next, pv_next, ph_next;
    logic rst_btn_reg, rst_btn_next;

    logic signed [33:0] x_reg, y_reg, x_next, y_next;
    logic signed [33:0] sin_reg, cos_reg, sin_next, cos_next;
    logic signed [20:0] z_reg, z_next;
    logic flip_reg, flip_next;
    logic [3:0] iter_reg, iter_next;
    logic [3:0] step_reg, step_next;
    logic [1:0] axis_reg, axis_next;

    logic signed [48:0] acc_reg, acc_next;
    logic signed [66:0] prod_reg, prod_next;

    logic m_tvalid_reg, m_tvalid_next;
    logic [OUT_BITS-1:0] m_tdata_reg, m_tdata_next;

    logic in_acc;
    logic load_out;

    // Shared multiplier operands.
    logic signed [48:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [66:0] mul_w;

    // Shared saturating adder.
    logic signed [31:0] add_goal;
    logic signed [33:0] add_delta;
    logic signed [34:0] add_sum;
    logic signed [31:0] add_sat;

    // Shared clamp unit.
    logic signed [33:0] cl_v, cl_cen, cl_lim, cl_lo, cl_hi, cl_res;
    logic signed [31:0] cl_sat;

    // CORDIC shift-add terms.
    logic signed [33:0] xs, ys;
    logic signed [20:0] seen_h_w, rr_w;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign seen_h_w = 21'(seen_h_reg);

    // Button yaw rate: the two buttons cancel.
    always_comb
    begin
        unique case (btn_reg)
            2'b01:   rr_w = -$signed({3'b000, yaw_rate_reg});
            2'b10:   rr_w = $signed({3'b000, yaw_rate_reg});
            default: rr_w = '0;
        endcase
    end

    // Operand selection for the multiplier.
    always_comb
    begin
        mul_a = acc_reg;
        mul_b = $signed({2'b00, step_time_reg});
        unique case (step_reg)
            MS_PC:   begin mul_a = 49'(cos_reg); mul_b = 18'(pit_reg); end
            MS_RS:   begin mul_a = 49'(sin_reg); mul_b = 18'(rol_reg); end
            MS_GX:   begin mul_a = 49'(sin_reg); mul_b = 18'(pit_reg); end
            MS_RC:   begin mul_a = 49'(cos_reg); mul_b = 18'(rol_reg); end
            MS_GY:   mul_a = 49'(thr_reg);
            MS_GZ:   mul_a = 49'(rr_w);
            default: mul_a = acc_reg;
        endcase
    end
    assign mul_w = mul_a * mul_b;

    // Increment selection and saturating add into one goal axis.
    always_comb
    begin
        add_goal  = goal_h_reg;
        add_delta = prod_reg[49:16];
        unique case (step_reg)
            MS_GX:
            begin
                add_goal  = goal_x_reg;
                add_delta = {{11{prod_reg[66]}}, prod_reg[66:44]};
            end
            MS_GY:
            begin
                add_goal  = goal_y_reg;
                add_delta = {{11{prod_reg[66]}}, prod_reg[66:44]};
            end
            MS_GZ:
            begin
                add_goal  = goal_z_reg;
                add_delta = prod_reg[47:14];
            end
            default:
            begin
                add_goal  = goal_h_reg;
                add_delta = prod_reg[49:16];
            end
        endcase
        add_sum = 35'(add_goal) + 35'(add_delta);
        if ((add_sum[34:31] != 4'b0000) && (add_sum[34:31] != 4'b1111))
            add_sat = add_sum[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            add_sat = add_sum[31:0];
    end

    // Clamp of one goal axis around the measured value.
    always_comb
    begin
        unique case (axis_reg)
            2'd0:    begin cl_v = 34'(goal_x_reg); cl_cen = 34'(seen_x_reg); end
            2'd1:    begin cl_v = 34'(goal_y_reg); cl_cen = 34'(seen_y_reg); end
            2'd2:    begin cl_v = 34'(goal_z_reg); cl_cen = 34'(seen_z_reg); end
            default: begin cl_v = 34'(goal_h_reg); cl_cen = 34'(seen_h_reg); end
        endcase
        if (axis_reg == 2'd3)
            cl_lim = $signed({16'd0, yaw_limit_reg});
        else
            cl_lim = $signed({3'd0, pos_limit_reg});
        cl_lo = cl_cen - cl_lim;
        cl_hi = cl_cen + cl_lim;
        if (cl_v < cl_lo)
            cl_res = cl_lo;
        else if (cl_v > cl_hi)
            cl_res = cl_hi;
        else
            cl_res = cl_v;
        if ((cl_res[33:31] != 3'b000) && (cl_res[33:31] != 3'b111))
            cl_sat = cl_res[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            cl_sat = cl_res[31:0];
    end

    assign xs = x_reg >>> iter_reg;
    assign ys = y_reg >>> iter_reg;

    // Sequencer and datapath next state.
    always_comb
    begin
        state_next    = state_reg;
        goal_x_next   = goal_x_reg;
        goal_y_next   = goal_y_reg;
        goal_z_next   = goal_z_reg;
        goal_h_next   = goal_h_reg;
        seen_x_next   = seen_x_reg;
        seen_y_next   = seen_y_reg;
        seen_z_next   = seen_z_reg;
        seen_h_next   = seen_h_reg;
        thr_next      = thr_reg;
        pit_next      = pit_reg;
        rol_next      = rol_reg;
        btn_next      = btn_reg;
        pv_next       = pv_reg;
        ph_next       = ph_reg;
        rst_btn_next  = rst_btn_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        z_next        = z_reg;
        flip_next     = flip_reg;
        sin_next      = sin_reg;
        cos_next      = cos_reg;
        iter_next     = iter_reg;
        step_next     = step_reg;
        axis_next     = axis_reg;
        acc_next      = acc_reg;
        prod_next     = prod_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        load_out      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (s_tuser == CMD_JOYSTICK))
                begin
                    thr_next     = s_tdata[15:0];
                    pit_next     = s_tdata[31:16];
                    rol_next     = s_tdata[47:32];
                    btn_next     = s_tdata[49:48];
                    rst_btn_next = s_tdata[50];
                    pv_next      = s_tdata[52:51];
                    ph_next      = s_tdata[54:53];
                    x_next       = CORDIC_GAIN;
                    y_next       = '0;
                    iter_next    = '0;
                    // Fold the heading by pi into [-pi/2, pi/2].
                    if (seen_h_w > 21'(Q_HALF_PI))
                    begin
                        z_next    = seen_h_w - 21'(Q_PI);
                        flip_next = 1'b1;
                    end
                    else if (seen_h_w < -21'(Q_HALF_PI))
                    begin
                        z_next    = seen_h_w + 21'(Q_PI);
                        flip_next = 1'b1;
                    end
                    else
                    begin
                        z_next    = seen_h_w;
                        flip_next = 1'b0;
                    end
                    state_next = ST_ROT;
                end
                else if (in_acc)
                begin
                    seen_x_next = s_tdata[86:55];
                    seen_y_next = s_tdata[118:87];
                    seen_z_next = s_tdata[150:119];
                    seen_h_next = s_tdata[169:151];
                    axis_next   = '0;
                    state_next  = ST_CLAMP;
                end
            end
            ST_ROT:
            begin
                // One CORDIC rotation per cycle.
                if (!z_reg[20])
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atan_lut(iter_reg);
                end
                else
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atan_lut(iter_reg);
                end
                iter_next = iter_reg + 4'd1;
                if (iter_reg == 4'd15)
                begin
                    step_next  = MS_TRIG;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                prod_next = mul_w;
                step_next = step_reg + 4'd1;
                unique case (step_reg)
                    MS_TRIG:
                    begin
                        sin_next = flip_reg ? -y_reg : y_reg;
                        cos_next = flip_reg ? -x_reg : x_reg;
                    end
                    MS_RS, MS_RC: acc_next = prod_reg[48:0];
                    MS_XDIFF:     acc_next = acc_reg - prod_reg[48:0];
                    MS_YSUM:      acc_next = acc_reg + prod_reg[48:0];
                    MS_GX:        goal_x_next = add_sat;
                    MS_GY:        goal_y_next = add_sat;
                    MS_GZ:        goal_z_next = add_sat;
                    MS_GH:        goal_h_next = add_sat;
                    MS_BUTTON:
                    begin
                        // Reset button first, then the pad; horizontal wins over vertical.
                        if (rst_btn_reg)
                        begin
                            goal_x_next = seen_x_reg;
                            goal_y_next = seen_y_reg;
                            goal_z_next = seen_z_reg;
                            goal_h_next = 32'(seen_h_reg);
                        end
                        priority if (ph_reg == PAD_PLUS)
                            goal_h_next = 32'(Q_HALF_PI);
                        else if (ph_reg == PAD_MINUS)
                            goal_h_next = -32'(Q_HALF_PI);
                        else if (pv_reg == PAD_MINUS)
                            goal_h_next = -32'(Q_PI);
                        else if (pv_reg == PAD_PLUS)
                            goal_h_next = '0;
                        state_next = ST_IDLE;
                    end
                    default: acc_next = acc_reg;
                endcase
            end
            ST_CLAMP:
            begin
                unique case (axis_reg)
                    2'd0:    goal_x_next = cl_sat;
                    2'd1:    goal_y_next = cl_sat;
                    2'd2:    goal_z_next = cl_sat;
                    default: goal_h_next = cl_sat;
                endcase
                axis_next = axis_reg + 2'd1;
                if (axis_reg == 2'd3)
                    state_next = ST_WRAP;
            end
            ST_WRAP:
            begin
                // The clamped heading is within one turn of the wrap range.
                if (goal_h_reg >= 32'(Q_PI))
                    goal_h_next = goal_h_reg - 32'(Q_TWO_PI);
                else if (goal_h_reg < -32'(Q_PI))
                    goal_h_next = goal_h_reg + 32'(Q_TWO_PI);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    load_out      = 1'b1;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, goal_h_reg[18:0], goal_z_reg,
                                     goal_y_reg, goal_x_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_time_reg <= STEP_TIME_RST;
            yaw_rate_reg  <= YAW_RATE_RST;
            pos_limit_reg <= POS_LIMIT_RST;
            yaw_limit_reg <= YAW_LIMIT_RST;
            goal_x_reg    <= '0;
            goal_y_reg    <= '0;
            goal_z_reg    <= GOAL_Z_RST;
            goal_h_reg    <= '0;
            seen_x_reg    <= '0;
            seen_y_reg    <= '0;
            seen_z_reg    <= '0;
            seen_h_reg    <= '0;
            thr_reg       <= '0;
            pit_reg       <= '0;
            rol_reg       <= '0;
            btn_reg       <= '0;
            pv_reg        <= '0;
            ph_reg        <= '0;
            rst_btn_reg   <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            z_reg         <= '0;
            flip_reg      <= 1'b0;
            sin_reg       <= '0;
            cos_reg       <= '0;
            iter_reg      <= '0;
            step_reg      <= '0;
            axis_reg      <= '0;
            acc_reg       <= '0;
            prod_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            goal_x_reg   <= goal_x_next;
            goal_y_reg   <= goal_y_next;
            goal_z_reg   <= goal_z_next;
            goal_h_reg   <= goal_h_next;
            seen_x_reg   <= seen_x_next;
            seen_y_reg   <= seen_y_next;
            seen_z_reg   <= seen_z_next;
            seen_h_reg   <= seen_h_next;
            thr_reg      <= thr_next;
            pit_reg      <= pit_next;
            rol_reg      <= rol_next;
            btn_reg      <= btn_next;
            pv_reg       <= pv_next;
            ph_reg       <= ph_next;
            rst_btn_reg  <= rst_btn_next;
            x_reg        <= x_next;
            y_reg        <= y_next;
            z_reg        <= z_next;
            flip_reg     <= flip_next;
            sin_reg      <= sin_next;
            cos_reg      <= cos_next;
            iter_reg     <= iter_next;
            step_reg     <= step_next;
            axis_reg     <= axis_next;
            acc_reg      <= acc_next;
            prod_reg     <= prod_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            // Configuration writes.
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_STEP_TIME: step_time_reg <= cfg_data[15:0];
                    REG_YAW_RATE:  yaw_rate_reg  <= cfg_data[17:0];
                    REG_POS_LIMIT: pos_limit_reg <= cfg_data;
                    REG_YAW_LIMIT: yaw_limit_reg <= cfg_data[17:0];
                    default:       step_time_reg <= step_time_reg;
                endcase
            end
        end
    end

    // A pose word goes straight to clamping.
    `TSI_ASSERT_NEXT(a_pose_to_clamp, in_acc && (s_tuser == CMD_POSE), state_reg == ST_CLAMP, "pose word did not start clamping")
    // Rotation only continues or hands over to the multiply sequence.
    `TSI_ASSERT_NEXT(a_rot_exit, state_reg == ST_ROT, (state_reg == ST_ROT) || (state_reg == ST_MAC), "bad exit from rotation")
    // Only the pose path loads the output register.
    `TSI_ASSERT(a_load_pose_only, !load_out || (state_reg == ST_DONE), "output loaded outside pose path")

endmodule
